FILE: design/b64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package b64_pkg;

  localparam int QueueDepth = 2;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3d;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [1:0]      kind;
    logic            last;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      b64_char = 8'h41 + w;
    end else if (v < 6'd52) begin
      b64_char = 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      b64_char = 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      b64_char = 8'h2b;
    end else begin
      b64_char = 8'h2f;
    end
  endfunction

  // bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      b64_value = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      b64_value = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      b64_value = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      b64_value = 7'd62;
    end else if (c == 8'h2f) begin
      b64_value = 7'd63;
    end else begin
      b64_value = 7'd64;
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/b64_front.sv
`timescale 1ns / 1ps
`default_nettype none
module b64_front import b64_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       mode_we,
  input  wire logic       mode_data,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  output job_t            job,
  output logic            job_valid
);

  logic       mode;
  logic [5:0] store;
  logic [2:0] count;
  logic [1:0] phase;
  logic       error_seen;

  logic [5:0] store_next;
  logic [2:0] count_next;
  logic [1:0] phase_next;
  logic       error_next;

  always_comb begin
    logic [5:0]  c0;
    logic [5:0]  c1;
    logic        two;
    logic [5:0]  flush;
    logic [2:0]  n;
    logic [1:0]  pad;
    logic [11:0] acc;
    logic        skip;
    logic [6:0]  v;
    job = '0;
    job_valid = 1'b0;
    store_next = store;
    count_next = count;
    phase_next = phase;
    error_next = error_seen;
    c0 = '0;
    c1 = '0;
    two = 1'b0;
    flush = '0;
    n = '0;
    pad = '0;
    acc = {store, data_byte[5:0]};
    skip = 1'b0;
    v = '0;
    if (!mode) begin
      case (count)
        3'd2: begin
          c0 = {store[1:0], data_byte[7:4]};
          store_next = {2'b00, data_byte[3:0]};
          count_next = 3'd4;
          flush = {data_byte[3:0], 2'b00};
        end
        3'd4: begin
          c0 = {store[3:0], data_byte[7:6]};
          c1 = data_byte[5:0];
          two = 1'b1;
          store_next = '0;
          count_next = 3'd0;
        end
        default: begin
          c0 = data_byte[7:2];
          store_next = {4'b0000, data_byte[1:0]};
          count_next = 3'd2;
          flush = {data_byte[1:0], 4'b0000};
        end
      endcase
      phase_next = (phase >= 2'd2) ? 2'd0 : phase + 2'd1;
      job.bytes[n[1:0]] = b64_char(c0);
      n = n + 3'd1;
      if (two) begin
        job.bytes[n[1:0]] = b64_char(c1);
        n = n + 3'd1;
      end
      if (end_of_message) begin
        if (count_next != 3'd0) begin
          job.bytes[n[1:0]] = b64_char(flush);
          n = n + 3'd1;
        end
        if (phase_next == 2'd1) begin
          pad = 2'd2;
        end else if (phase_next == 2'd2) begin
          pad = 2'd1;
        end
        if (pad != 2'd0) begin
          job.bytes[n[1:0]] = PAD_CHAR;
          n = n + 3'd1;
        end
        if (pad == 2'd2) begin
          job.bytes[n[1:0]] = PAD_CHAR;
          n = n + 3'd1;
        end
      end
      job.kind = KIND_DATA;
      job.last = end_of_message;
      job.last_idx = 2'(n - 3'd1);
      job_valid = 1'b1;
    end else begin
      skip = (data_byte == 8'h20) || (data_byte >= 8'h09 && data_byte <= 8'h0d) ||
             (data_byte == PAD_CHAR);
      v = b64_value(data_byte);
      acc = {store, v[5:0]};
      job.kind = KIND_END;
      if (!error_seen && !skip) begin
        if (v[6]) begin
          error_next = 1'b1;
          job.kind = KIND_ERROR;
          job_valid = 1'b1;
        end else begin
          store_next = v[5:0];
          case (count)
            3'd6: begin
              job.bytes[0] = acc[11:4];
              count_next = 3'd4;
              job.kind = KIND_DATA;
              job_valid = 1'b1;
            end
            3'd4: begin
              job.bytes[0] = acc[9:2];
              count_next = 3'd2;
              job.kind = KIND_DATA;
              job_valid = 1'b1;
            end
            3'd2: begin
              job.bytes[0] = acc[7:0];
              count_next = 3'd0;
              job.kind = KIND_DATA;
              job_valid = 1'b1;
            end
            default: begin
              count_next = 3'd6;
            end
          endcase
        end
      end
      job.last = end_of_message;
      job.last_idx = 2'd0;
      job_valid = job_valid || end_of_message;
    end
    if (end_of_message) begin
      store_next = '0;
      count_next = '0;
      phase_next = '0;
      error_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      store <= '0;
      count <= '0;
      phase <= '0;
      error_seen <= 1'b0;
    end else if (mode_we) begin
      mode <= mode_data;
      store <= '0;
      count <= '0;
      phase <= '0;
      error_seen <= 1'b0;
    end else if (accept) begin
      store <= store_next;
      count <= count_next;
      phase <= phase_next;
      error_seen <= error_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/b64_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module b64_queue import b64_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  job_t      wr_job,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      nonempty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full = (fill == CntW'(DEPTH));
  assign nonempty = (fill != '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CntW'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/b64_back.sv
`timescale 1ns / 1ps
`default_nettype none
module b64_back import b64_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  job_t            job,
  input  wire logic       job_ready,
  output logic            job_take,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last_result
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       final_beat;

  assign empty = !out_valid;
  assign load = job_ready && (!out_valid || pop);
  assign final_beat = (idx == job.last_idx);
  assign job_take = load && final_beat;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= job.bytes[idx];
      kind <= job.kind;
      last_result <= job.last && final_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= final_beat ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/base64_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming Base64 codec (standard alphabet). mode 0 encodes one raw byte per
// beat into one to four characters (padding on the end-of-message byte);
// mode 1 decodes one character per beat into at most one result byte, error
// or end marker. Each input beat is classified and its results worked out in
// the cycle it is taken, then queued; the result side drains the queue at one
// beat per cycle while pop keeps up. A new input beat can be taken whenever
// the queue is not full, and each result is handed out on its own beat: one or
// two mid-message in encode (four results per three bytes sustained), up to
// four on the end-of-message byte, at most one in decode. Write mode only
// while the block is idle; the write clears the message state.
module base64_codec import b64_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       mode_we,
  input  wire logic       mode_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last_result
);

  job_t front_job;
  job_t head_job;
  logic front_valid;
  logic accept;
  logic head_ready;
  logic head_take;

  assign accept = push && !full;

  b64_front u_front (
    .clk            (clk),
    .rst            (rst),
    .mode_we        (mode_we),
    .mode_data      (mode_data),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .job            (front_job),
    .job_valid      (front_valid)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && front_valid),
    .wr_job   (front_job),
    .full     (full),
    .rd_en    (head_take),
    .rd_job   (head_job),
    .nonempty (head_ready)
  );

  b64_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .job_ready   (head_ready),
    .job_take    (head_take),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .kind        (kind),
    .last_result (last_result)
  );

endmodule
`default_nettype wire
